// ===== design/ps2kbd_pkg.sv =====
// Shared types, command codes and scan-code set 2 lookup tables for the PS/2 decoder.
package ps2kbd_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int KM_ROWS        = 32;
  localparam int KM_AW          = 5;

  localparam logic [1:0] CMD_SCAN  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [7:0] SC_EXTEND  = 8'hE0;
  localparam logic [7:0] SC_RELEASE = 8'hF0;
  localparam logic [8:0] EV_PRESS   = 9'h100;

  typedef struct packed {
    logic             en;
    logic [KM_AW-1:0] addr;
  } km_rd_t;

  typedef struct packed {
    logic             en;
    logic [KM_AW-1:0] addr;
    logic [7:0]       data;
  } km_wr_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [8:0] data;
  } evq_ctl_t;

  function automatic logic [7:0] base_lookup(input logic [7:0] b);
    logic [7:0] k;
    k = 8'h00;
    case (b)
      8'h01: k = 8'h78; 8'h03: k = 8'h74; 8'h04: k = 8'h72; 8'h05: k = 8'h70;
      8'h06: k = 8'h71; 8'h07: k = 8'h7B; 8'h09: k = 8'h79; 8'h0A: k = 8'h77;
      8'h0B: k = 8'h75; 8'h0C: k = 8'h73; 8'h0D: k = 8'h09; 8'h0E: k = 8'hC0;
      8'h11: k = 8'hA4; 8'h12: k = 8'hA0; 8'h14: k = 8'hA2; 8'h15: k = 8'h51;
      8'h16: k = 8'h31; 8'h1A: k = 8'h5A; 8'h1B: k = 8'h53; 8'h1C: k = 8'h41;
      8'h1D: k = 8'h57; 8'h1E: k = 8'h32; 8'h21: k = 8'h43; 8'h22: k = 8'h58;
      8'h23: k = 8'h44; 8'h24: k = 8'h45; 8'h25: k = 8'h34; 8'h26: k = 8'h33;
      8'h29: k = 8'h20; 8'h2A: k = 8'h56; 8'h2B: k = 8'h46; 8'h2C: k = 8'h54;
      8'h2D: k = 8'h52; 8'h2E: k = 8'h35; 8'h31: k = 8'h4E; 8'h32: k = 8'h42;
      8'h33: k = 8'h48; 8'h34: k = 8'h47; 8'h35: k = 8'h59; 8'h36: k = 8'h36;
      8'h3A: k = 8'h4D; 8'h3B: k = 8'h4A; 8'h3C: k = 8'h55; 8'h3D: k = 8'h37;
      8'h3E: k = 8'h38; 8'h41: k = 8'hBC; 8'h42: k = 8'h4B; 8'h43: k = 8'h49;
      8'h44: k = 8'h4F; 8'h45: k = 8'h30; 8'h46: k = 8'h39; 8'h49: k = 8'hBE;
      8'h4A: k = 8'hBF; 8'h4B: k = 8'h4C; 8'h4C: k = 8'hBA; 8'h4D: k = 8'h50;
      8'h4E: k = 8'hBD; 8'h52: k = 8'hDE; 8'h54: k = 8'hDB; 8'h55: k = 8'hBB;
      8'h58: k = 8'h14; 8'h59: k = 8'hA1; 8'h5A: k = 8'h0D; 8'h5B: k = 8'hDD;
      8'h5D: k = 8'hDC; 8'h66: k = 8'h08; 8'h69: k = 8'h61; 8'h6B: k = 8'h64;
      8'h6C: k = 8'h67; 8'h70: k = 8'h60; 8'h71: k = 8'h6E; 8'h72: k = 8'h62;
      8'h73: k = 8'h65; 8'h74: k = 8'h66; 8'h75: k = 8'h68; 8'h76: k = 8'h1B;
      8'h77: k = 8'h90; 8'h78: k = 8'h7A; 8'h79: k = 8'h6B; 8'h7A: k = 8'h63;
      8'h7B: k = 8'h6D; 8'h7C: k = 8'h6A; 8'h7D: k = 8'h69; 8'h7E: k = 8'h91;
      8'h83: k = 8'h76;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] ext_lookup(input logic [7:0] b);
    logic [7:0] k;
    k = 8'h00;
    case (b)
      8'h11: k = 8'hA5; 8'h14: k = 8'hA3; 8'h1F: k = 8'h5B; 8'h27: k = 8'h5C;
      8'h2F: k = 8'h5D; 8'h4A: k = 8'h6F; 8'h5A: k = 8'h5E; 8'h69: k = 8'h23;
      8'h6B: k = 8'h25; 8'h6C: k = 8'h24; 8'h70: k = 8'h2D; 8'h71: k = 8'h2E;
      8'h72: k = 8'h28; 8'h74: k = 8'h27; 8'h75: k = 8'h26; 8'h7A: k = 8'h22;
      8'h7D: k = 8'h21;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] scan_lookup(input logic ext, input logic [7:0] b);
    return ext ? ext_lookup(b) : base_lookup(b);
  endfunction

endpackage

// ===== design/ps2_keyboard_scan_decoder.sv =====
// PS/2 scan-code set 2 decoder top level: prefix flags, table decode, key map and event queue.
//
// Takes one command per cycle (scan byte, pop, key query) while out_ready is high and returns
// exactly one result per command from the output registers. The accept cycle decodes the byte
// through the scan table and issues reads to the key-map memory and the event-queue memory;
// the following stage merges the press or release into the key-map row and writes it back,
// forwarding that row to a command that reads it in the same edge. Throughput is one command
// per cycle while out_ready is high, set by the single read-modify-write slot on the key map.
// The key map comes out of reset cleared through per-row valid bits, with no clearing pass;
// the event queue holds FIFO_DEPTH events and drops new events when full.
module ps2_keyboard_scan_decoder import ps2kbd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_scan_byte,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_event_valid,
  output logic [8:0] out_event_code,
  output logic       out_key_is_down,
  output logic       out_event_dropped,
  output logic [4:0] out_fifo_level
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic             upd;
    logic             query;
    logic             popped;
    logic             press;
    logic             dropped;
    logic [KM_AW-1:0] row;
    logic [2:0]       bit_sel;
    logic [4:0]       level;
  } s1_t;

  logic          ext_flag_r;
  logic          rel_flag_r;
  logic          s1_vld_r;
  s1_t           s1_r;
  s1_t           s1_nxt;
  logic          out_vld_r;
  logic          ev_vld_r;
  logic [8:0]    ev_code_r;
  logic          down_r;
  logic          drop_r;
  logic [4:0]    level_r;

  logic          accept;
  logic          s1_move;
  logic          is_scan;
  logic          is_prefix;
  logic [7:0]    key;
  logic          key_hit;
  logic          full;
  logic [CW-1:0] count;
  logic [CW-1:0] level_after;
  logic [CW+4:0] level_ext;
  logic [8:0]    pop_data;
  logic [7:0]    row_data;
  logic [7:0]    bit_mask;
  km_rd_t        km_rd;
  km_wr_t        km_wr;
  evq_ctl_t      evq_ctl;

  assign s1_move  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_move;
  assign accept   = in_valid && in_ready;

  assign is_scan   = (in_cmd == CMD_SCAN);
  assign is_prefix = (in_scan_byte == SC_EXTEND) || (in_scan_byte == SC_RELEASE);
  assign key       = scan_lookup(ext_flag_r, in_scan_byte);
  assign key_hit   = is_scan && !is_prefix && (key != 8'h00);
  assign full      = (count == CW'(FIFO_DEPTH));

  always_comb begin
    evq_ctl.push = accept && key_hit && !full;
    evq_ctl.pop  = accept && (in_cmd == CMD_POP) && (count != '0);
    evq_ctl.data = rel_flag_r ? {1'b0, key} : ({1'b0, key} | EV_PRESS);
  end

  always_comb begin
    level_after = count;
    if (evq_ctl.push) begin
      level_after = count + 1'b1;
    end else if (evq_ctl.pop) begin
      level_after = count - 1'b1;
    end
    level_ext = {5'd0, level_after};
  end

  always_comb begin
    km_rd.en   = accept && (key_hit || (in_cmd == CMD_QUERY));
    km_rd.addr = (in_cmd == CMD_QUERY) ? in_key_code[7:3] : key[7:3];
  end

  always_comb begin
    s1_nxt.upd     = key_hit;
    s1_nxt.query   = (in_cmd == CMD_QUERY);
    s1_nxt.popped  = evq_ctl.pop;
    s1_nxt.press   = !rel_flag_r;
    s1_nxt.dropped = key_hit && full;
    s1_nxt.row     = km_rd.addr;
    s1_nxt.bit_sel = (in_cmd == CMD_QUERY) ? in_key_code[2:0] : key[2:0];
    s1_nxt.level   = level_ext[4:0];
  end

  assign bit_mask = 8'h01 << s1_r.bit_sel;

  always_comb begin
    km_wr.en   = s1_move && s1_r.upd;
    km_wr.addr = s1_r.row;
    km_wr.data = s1_r.press ? (row_data | bit_mask) : (row_data & ~bit_mask);
  end

  ps2kbd_keymap u_keymap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (km_rd),
    .wr      (km_wr),
    .rd_data (row_data)
  );

  ps2kbd_evq #(.DEPTH(FIFO_DEPTH)) u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (evq_ctl),
    .count    (count),
    .pop_data (pop_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_flag_r <= 1'b0;
      rel_flag_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (accept && is_scan) begin
        priority if (in_scan_byte == SC_EXTEND) begin
          ext_flag_r <= 1'b1;
        end else if (in_scan_byte == SC_RELEASE) begin
          rel_flag_r <= 1'b1;
        end else begin
          ext_flag_r <= 1'b0;
          rel_flag_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_move) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_move) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      ev_vld_r  <= s1_r.popped;
      ev_code_r <= s1_r.popped ? pop_data : 9'h000;
      down_r    <= s1_r.query && row_data[s1_r.bit_sel];
      drop_r    <= s1_r.dropped;
      level_r   <= s1_r.level;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_valid   = ev_vld_r;
  assign out_event_code    = ev_code_r;
  assign out_key_is_down   = down_r;
  assign out_event_dropped = drop_r;
  assign out_fifo_level    = level_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(FIFO_DEPTH))
    else $error("event queue count above depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && drop_r |-> level_r == level_ext[4:0] || level_r == 5'(FIFO_DEPTH))
    else $error("dropped event without a full queue");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("transfer taken while the pipeline is blocked");

  a_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ev_vld_r |-> !down_r && !drop_r)
    else $error("pop result carries key or drop status");
`endif

endmodule

// ===== design/ps2kbd_keymap.sv =====
// Key-down map: 32 x 8 synchronous memory with per-row valid bits and write forwarding.
module ps2kbd_keymap import ps2kbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  km_rd_t     rd,
  input  km_wr_t     wr,
  output logic [7:0] rd_data
);

  logic [7:0]         mem [KM_ROWS];
  logic [KM_ROWS-1:0] row_vld_r;
  logic [7:0]         mem_q_r;
  logic [7:0]         fwd_r;
  logic               vld_q_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q_r <= mem[rd.addr];
      fwd_r   <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      vld_q_r   <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_q_r <= row_vld_r[rd.addr];
        hit_r   <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  // same-edge write to the row being read wins over the stale memory word
  assign rd_data = hit_r ? fwd_r : (vld_q_r ? mem_q_r : 8'h00);

endmodule

// ===== design/ps2kbd_evq.sv =====
// Event queue: circular buffer in a synchronous memory with pointers and fill count.
module ps2kbd_evq import ps2kbd_pkg::*; #(
  parameter  int DEPTH = FIFO_DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int PW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  evq_ctl_t      ctl,
  output logic [CW-1:0] count,
  output logic [8:0]    pop_data
);

  logic [8:0]    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [8:0]    pop_data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.data;
    end
    if (ctl.pop) begin
      pop_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
        count_r  <= count_r + 1'b1;
      end else if (ctl.pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        count_r  <= count_r - 1'b1;
      end
    end
  end

  assign count    = count_r;
  assign pop_data = pop_data_r;

endmodule
